// ----- rtl/core/ism_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ism_pkg
// Shared types and constants of the integer stack machine.
// ----------------------------------------------------------------------------
package ism_pkg;

   localparam int DEPTH      = 32;
   localparam int SLOT_W     = $clog2(DEPTH);
   localparam int COUNT_W    = $clog2(DEPTH + 1);
   localparam int DATA_W     = 32;
   localparam int CMD_W      = 3;
   localparam int STATUS_W   = 3;
   localparam int CHAR_W     = 7;
   localparam int RSP_DATA_W = 16;

   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = CHAR_W'(10);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH  = 3'd0,
      CMD_MUL   = 3'd1,
      CMD_PCHAR = 3'd2,
      CMD_PSTR  = 3'd3,
      CMD_ROTL  = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_EMPTY = 3'd1,
      ST_SHORT = 3'd2,
      ST_RANGE = 3'd3,
      ST_FULL  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OFF_COUNT,
      OFF_TOP,
      OFF_SECOND,
      OFF_IDX
   } off_type;

   typedef enum logic [1:0] {
      EMIT_REPORT,
      EMIT_CHAR,
      EMIT_NEWLINE
   } emit_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_MUL_READ2,
      S_MUL_WRITE,
      S_PCHAR_CHECK,
      S_PSTR_READ,
      S_PSTR_CHECK,
      S_CHAR_EMIT,
      S_NEWLINE,
      S_ROTL_WRITE,
      S_REPORT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       fail;
      status_type fail_status;
      off_type    off;
      logic       rd_en;
      logic       latch_op;
      logic       push_wr;
      logic       mul_wr;
      logic       rotl_wr;
      logic       take_char;
      logic       idx_dec;
      logic       emit;
      emit_type   emit_kind;
   } ctl_cmd_type;

   typedef struct packed {
      cmd_type            command;
      logic [COUNT_W-1:0] count;
      logic               full;
      logic               lt2;
      logic               empty;
      logic               idx_zero;
      logic               over_range;
      logic               stop_char;
      logic               out_free;
   } dp_status_type;

endpackage

// ----- rtl/core/ism_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ism_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ism_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ism_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ism_ctrl
// Command sequencer: steps each command through reads, writes and beats.
// ----------------------------------------------------------------------------
module ism_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  ism_pkg::dp_status_type dp_status,
   output ism_pkg::ctl_cmd_type   ctl_cmd
);

   ism_pkg::state_type state_ff;
   ism_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ism_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ism_pkg::S_IDLE: begin
            if (req_tvalid) state_in = ism_pkg::S_DECODE;
         end
         ism_pkg::S_DECODE: begin
            case (dp_status.command)
               ism_pkg::CMD_MUL:
                  state_in = dp_status.lt2 ? ism_pkg::S_REPORT : ism_pkg::S_MUL_READ2;
               ism_pkg::CMD_PCHAR:
                  state_in = dp_status.empty ? ism_pkg::S_REPORT : ism_pkg::S_PCHAR_CHECK;
               ism_pkg::CMD_PSTR:
                  state_in = ism_pkg::S_PSTR_READ;
               ism_pkg::CMD_ROTL:
                  state_in = dp_status.lt2 ? ism_pkg::S_REPORT : ism_pkg::S_ROTL_WRITE;
               default:
                  state_in = ism_pkg::S_REPORT;
            endcase
         end
         ism_pkg::S_MUL_READ2:   state_in = ism_pkg::S_MUL_WRITE;
         ism_pkg::S_MUL_WRITE:   state_in = ism_pkg::S_REPORT;
         ism_pkg::S_ROTL_WRITE:  state_in = ism_pkg::S_REPORT;
         ism_pkg::S_PCHAR_CHECK: begin
            state_in = dp_status.over_range ? ism_pkg::S_REPORT : ism_pkg::S_CHAR_EMIT;
         end
         ism_pkg::S_PSTR_READ: begin
            state_in = dp_status.idx_zero ? ism_pkg::S_NEWLINE : ism_pkg::S_PSTR_CHECK;
         end
         ism_pkg::S_PSTR_CHECK: begin
            state_in = dp_status.stop_char ? ism_pkg::S_NEWLINE : ism_pkg::S_CHAR_EMIT;
         end
         ism_pkg::S_CHAR_EMIT: begin
            if (dp_status.out_free) begin
               state_in = (dp_status.command == ism_pkg::CMD_PSTR) ?
                          ism_pkg::S_PSTR_READ : ism_pkg::S_NEWLINE;
            end
         end
         ism_pkg::S_NEWLINE,
         ism_pkg::S_REPORT: begin
            if (dp_status.out_free) state_in = ism_pkg::S_IDLE;
         end
         default: state_in = ism_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl_cmd             = '0;
      ctl_cmd.fail_status = ism_pkg::ST_OK;
      ctl_cmd.off         = ism_pkg::OFF_COUNT;
      ctl_cmd.emit_kind   = ism_pkg::EMIT_REPORT;
      req_tready          = 1'b0;
      case (state_ff)
         ism_pkg::S_IDLE: begin
            req_tready   = 1'b1;
            ctl_cmd.load = req_tvalid;
         end
         ism_pkg::S_DECODE: begin
            case (dp_status.command)
               ism_pkg::CMD_PUSH: begin
                  if (dp_status.full) begin
                     ctl_cmd.fail        = 1'b1;
                     ctl_cmd.fail_status = ism_pkg::ST_FULL;
                  end else begin
                     ctl_cmd.push_wr = 1'b1;
                     ctl_cmd.off     = ism_pkg::OFF_COUNT;
                  end
               end
               ism_pkg::CMD_MUL: begin
                  if (dp_status.lt2) begin
                     ctl_cmd.fail        = 1'b1;
                     ctl_cmd.fail_status = ism_pkg::ST_SHORT;
                  end else begin
                     ctl_cmd.rd_en = 1'b1;
                     ctl_cmd.off   = ism_pkg::OFF_TOP;
                  end
               end
               ism_pkg::CMD_PCHAR: begin
                  if (dp_status.empty) begin
                     ctl_cmd.fail        = 1'b1;
                     ctl_cmd.fail_status = ism_pkg::ST_EMPTY;
                  end else begin
                     ctl_cmd.rd_en = 1'b1;
                     ctl_cmd.off   = ism_pkg::OFF_TOP;
                  end
               end
               ism_pkg::CMD_ROTL: begin
                  ctl_cmd.rd_en = !dp_status.lt2;
                  ctl_cmd.off   = ism_pkg::OFF_TOP;
               end
               default: begin
               end
            endcase
         end
         ism_pkg::S_MUL_READ2: begin
            ctl_cmd.latch_op = 1'b1;
            ctl_cmd.rd_en    = 1'b1;
            ctl_cmd.off      = ism_pkg::OFF_SECOND;
         end
         ism_pkg::S_MUL_WRITE: begin
            ctl_cmd.mul_wr = 1'b1;
            ctl_cmd.off    = ism_pkg::OFF_SECOND;
         end
         ism_pkg::S_ROTL_WRITE: begin
            ctl_cmd.rotl_wr = 1'b1;
         end
         ism_pkg::S_PCHAR_CHECK: begin
            if (dp_status.over_range) begin
               ctl_cmd.fail        = 1'b1;
               ctl_cmd.fail_status = ism_pkg::ST_RANGE;
            end else begin
               ctl_cmd.take_char = 1'b1;
            end
         end
         ism_pkg::S_PSTR_READ: begin
            ctl_cmd.rd_en = !dp_status.idx_zero;
            ctl_cmd.off   = ism_pkg::OFF_IDX;
         end
         ism_pkg::S_PSTR_CHECK: begin
            ctl_cmd.take_char = !dp_status.stop_char;
            ctl_cmd.idx_dec   = !dp_status.stop_char;
         end
         ism_pkg::S_CHAR_EMIT: begin
            ctl_cmd.emit      = dp_status.out_free;
            ctl_cmd.emit_kind = ism_pkg::EMIT_CHAR;
         end
         ism_pkg::S_NEWLINE: begin
            ctl_cmd.emit      = dp_status.out_free;
            ctl_cmd.emit_kind = ism_pkg::EMIT_NEWLINE;
         end
         ism_pkg::S_REPORT: begin
            ctl_cmd.emit      = dp_status.out_free;
            ctl_cmd.emit_kind = ism_pkg::EMIT_REPORT;
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- rtl/core/ism_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ism_datapath
// Stack store, pointers, multiplier and the result register.
// ----------------------------------------------------------------------------
module ism_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [ism_pkg::CMD_W-1:0]        req_tuser,
   input  logic [ism_pkg::DATA_W-1:0]       req_tdata,
   input  ism_pkg::ctl_cmd_type             ctl_cmd,
   output ism_pkg::dp_status_type           dp_status,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ism_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast
);

   function automatic logic [ism_pkg::SLOT_W-1:0] slot_of(
      input logic [ism_pkg::SLOT_W-1:0]  bottom,
      input logic [ism_pkg::COUNT_W-1:0] k
   );
      logic [ism_pkg::COUNT_W:0] sum;
      sum = (ism_pkg::COUNT_W + 1)'(bottom) + (ism_pkg::COUNT_W + 1)'(k);
      if (sum >= (ism_pkg::COUNT_W + 1)'(ism_pkg::DEPTH)) begin
         sum = sum - (ism_pkg::COUNT_W + 1)'(ism_pkg::DEPTH);
      end
      return sum[ism_pkg::SLOT_W-1:0];
   endfunction

   ism_pkg::cmd_type              cmd_ff, cmd_in;
   logic [ism_pkg::DATA_W-1:0]    val_ff, val_in;
   logic [ism_pkg::DATA_W-1:0]    op_ff, op_in;
   logic [ism_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [ism_pkg::COUNT_W-1:0]   idx_ff, idx_in;
   logic [ism_pkg::SLOT_W-1:0]    bottom_ff, bottom_in;
   ism_pkg::status_type           st_ff, st_in;
   logic [ism_pkg::CHAR_W-1:0]    char_ff, char_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   ism_pkg::status_type           rsp_st_ff, rsp_st_in;
   logic [ism_pkg::CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                          rsp_cv_ff, rsp_cv_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [ism_pkg::COUNT_W-1:0]   offset;
   logic [ism_pkg::SLOT_W-1:0]    addr;
   logic [ism_pkg::SLOT_W-1:0]    bottom_dec;
   logic [ism_pkg::DATA_W-1:0]    rd_data;
   logic [ism_pkg::DATA_W-1:0]    product;
   logic                          wr_en;
   logic [ism_pkg::SLOT_W-1:0]    wr_addr;
   logic [ism_pkg::DATA_W-1:0]    wr_data;
   logic                          out_free;

   always_comb begin
      case (ctl_cmd.off)
         ism_pkg::OFF_TOP:    offset = count_ff - ism_pkg::COUNT_W'(1);
         ism_pkg::OFF_SECOND: offset = count_ff - ism_pkg::COUNT_W'(2);
         ism_pkg::OFF_IDX:    offset = idx_ff - ism_pkg::COUNT_W'(1);
         default:             offset = count_ff;
      endcase
   end

   assign addr       = slot_of(bottom_ff, offset);
   assign bottom_dec = (bottom_ff == '0) ? ism_pkg::SLOT_W'(ism_pkg::DEPTH - 1)
                                         : bottom_ff - ism_pkg::SLOT_W'(1);
   assign product    = op_ff * rd_data;
   assign wr_en      = ctl_cmd.push_wr || ctl_cmd.mul_wr || ctl_cmd.rotl_wr;
   assign wr_addr    = ctl_cmd.rotl_wr ? bottom_dec : addr;

   always_comb begin
      if (ctl_cmd.push_wr)     wr_data = val_ff;
      else if (ctl_cmd.mul_wr) wr_data = product;
      else                     wr_data = rd_data;
   end

   ism_ram #(
      .WIDTH (ism_pkg::DATA_W),
      .DEPTH (ism_pkg::DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctl_cmd.rd_en),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd_in    = cmd_ff;
      val_in    = val_ff;
      op_in     = op_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      bottom_in = bottom_ff;
      st_in     = st_ff;
      char_in   = char_ff;
      if (ctl_cmd.load) begin
         cmd_in = ism_pkg::cmd_type'(req_tuser);
         val_in = req_tdata;
         idx_in = count_ff;
         st_in  = ism_pkg::ST_OK;
      end
      if (ctl_cmd.fail) begin
         count_in  = '0;
         bottom_in = '0;
         st_in     = ctl_cmd.fail_status;
      end
      if (ctl_cmd.push_wr)   count_in  = count_ff + ism_pkg::COUNT_W'(1);
      if (ctl_cmd.mul_wr)    count_in  = count_ff - ism_pkg::COUNT_W'(1);
      if (ctl_cmd.rotl_wr)   bottom_in = bottom_dec;
      if (ctl_cmd.latch_op)  op_in     = rd_data;
      if (ctl_cmd.take_char) char_in   = rd_data[ism_pkg::CHAR_W-1:0];
      if (ctl_cmd.idx_dec)   idx_in    = idx_ff - ism_pkg::COUNT_W'(1);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_cv_in    = rsp_cv_ff;
      rsp_last_in  = rsp_last_ff;
      if (ctl_cmd.emit) begin
         rsp_valid_in = 1'b1;
         case (ctl_cmd.emit_kind)
            ism_pkg::EMIT_CHAR: begin
               rsp_st_in   = ism_pkg::ST_OK;
               rsp_char_in = char_ff;
               rsp_cv_in   = 1'b1;
               rsp_last_in = 1'b0;
            end
            ism_pkg::EMIT_NEWLINE: begin
               rsp_st_in   = ism_pkg::ST_OK;
               rsp_char_in = ism_pkg::NEWLINE_CHAR;
               rsp_cv_in   = 1'b1;
               rsp_last_in = 1'b1;
            end
            default: begin
               rsp_st_in   = st_ff;
               rsp_char_in = '0;
               rsp_cv_in   = 1'b0;
               rsp_last_in = 1'b1;
            end
         endcase
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         bottom_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         bottom_ff    <= bottom_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      val_ff      <= val_in;
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      st_ff       <= st_in;
      char_ff     <= char_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_char_ff <= rsp_char_in;
      rsp_cv_ff   <= rsp_cv_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign dp_status.command    = cmd_ff;
   assign dp_status.count      = count_ff;
   assign dp_status.full       = (count_ff == ism_pkg::COUNT_W'(ism_pkg::DEPTH));
   assign dp_status.lt2        = (count_ff < ism_pkg::COUNT_W'(2));
   assign dp_status.empty      = (count_ff == '0);
   assign dp_status.idx_zero   = (idx_ff == '0);
   assign dp_status.over_range = (rd_data[ism_pkg::DATA_W-1:ism_pkg::CHAR_W] != '0);
   assign dp_status.stop_char  = (rd_data == '0) ||
                                 (rd_data[ism_pkg::DATA_W-1:ism_pkg::CHAR_W] != '0);
   assign dp_status.out_free   = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(ism_pkg::RSP_DATA_W - ism_pkg::STATUS_W - ism_pkg::CHAR_W - 1)'(0),
                        rsp_cv_ff, rsp_char_ff, rsp_st_ff};

endmodule

// ----- rtl/core/integer_stack_machine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_stack_machine
// Stack machine on a bounded circular stack of signed 32-bit integers.
// ----------------------------------------------------------------------------
// Usage:
//  req_ channel: one beat per command; tuser carries the command code, tdata
//  the push value. rsp_ channel: one or more beats per command, tlast on the
//  final one; tdata carries status, character and its valid flag.
//  Commands run one at a time through a single stack RAM (one write and one
//  registered read port). mul makes two reads, then a multiply-and-write;
//  pstr prints one character per entry, ending at a zero or out-of-range entry.
//  req_tready is high only while no command is in progress; a result beat
//  sits in an output register, so the next command is taken while it waits.
//  A stalled receiver holds the current command at its next beat.
//  Errors return their status and empty the stack. Reset empties the stack
//  and drops any pending beat; no clearing pass is needed.
// ----------------------------------------------------------------------------
module integer_stack_machine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ism_pkg::DATA_W-1:0]     req_tdata,   // [31:0] push_value
   input  logic [ism_pkg::CMD_W-1:0]      req_tuser,   // [2:0] command
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ism_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [2:0] status, [9:3] character,
                                                       // [10] char_valid
   output logic                           rsp_tlast
);

   ism_pkg::ctl_cmd_type   ctl_cmd;
   ism_pkg::dp_status_type dp_status;

   ism_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .ctl_cmd    (ctl_cmd)
   );

   ism_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .ctl_cmd    (ctl_cmd),
      .dp_status  (dp_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      dp_status.count <= ism_pkg::COUNT_W'(ism_pkg::DEPTH))
      else $error("stack count beyond depth");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.emit |-> dp_status.out_free)
      else $error("beat written over a pending result");

   a_fail_clears: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.fail |=> dp_status.count == '0)
      else $error("error did not empty the stack");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second command taken while busy");

endmodule

// ----- verif/tb_integer_stack_machine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_stack_machine
// Self-checking bench for the integer stack machine. A table of directed
// commands (empty, short and full stack, out-of-range characters, extremes
// of the push value, spare command codes) is followed by random commands,
// about 480 commands in all, mostly runs of pushes with printable content
// interleaved with mul, pchar, pstr and rotl. Every result beat is checked
// field by field against a shadow copy of the stack kept by the bench. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_integer_stack_machine;

   localparam int NUM_ROWS    = 29;
   localparam int TOTAL_ITEMS = 480;
   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 40;

   localparam logic [ism_pkg::CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
   localparam logic [ism_pkg::CMD_W-1:0] CMD_SPARE_MID = 3'd6;
   localparam logic [ism_pkg::CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

   typedef struct {
      ism_pkg::status_type        status;
      logic [ism_pkg::CHAR_W-1:0] character;
      logic                       char_valid;
      logic                       last;
   } beat_type;

   typedef struct packed {
      logic [ism_pkg::CMD_W-1:0]  cmd;
      logic [ism_pkg::DATA_W-1:0] value;
      logic                       typed;
      ism_pkg::status_type        status;
   } row_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [ism_pkg::DATA_W-1:0]     req_tdata;
   logic [ism_pkg::CMD_W-1:0]      req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [ism_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;

   logic [ism_pkg::DATA_W-1:0] shadow_stack [ism_pkg::DEPTH];
   int                         shadow_bottom;
   int                         shadow_count;
   beat_type                   command_beats [$];
   beat_type                   expected_beats [$];

   bit no_idle;
   int error_count;
   int idle_cycles;
   int commands_sent;
   int stall_left;

   // note: '{cmd, value, typed, status}
   row_type directed_rows [NUM_ROWS] = '{
      '{ism_pkg::CMD_PCHAR, 32'h0000_0000, 1'b1, ism_pkg::ST_EMPTY},
      '{ism_pkg::CMD_MUL,   32'h0000_0000, 1'b1, ism_pkg::ST_SHORT},
      '{ism_pkg::CMD_PSTR,  32'h0000_0000, 1'b0, ism_pkg::ST_OK},
      '{ism_pkg::CMD_ROTL,  32'h0000_0000, 1'b1, ism_pkg::ST_OK},
      '{ism_pkg::CMD_PUSH,  32'h7FFF_FFFF, 1'b1, ism_pkg::ST_OK},
      '{ism_pkg::CMD_MUL,   32'h0000_0000, 1'b1, ism_pkg::ST_SHORT},
      '{ism_pkg::CMD_PUSH,  32'h7FFF_FFFF, 1'b1, ism_pkg::ST_OK},
      '{ism_pkg::CMD_ROTL,  32'h0000_0000, 1'b1, ism_pkg::ST_OK},
      '{ism_pkg::CMD_PCHAR, 32'h0000_0000, 1'b1, ism_pkg::ST_RANGE},
      '{ism_pkg::CMD_PUSH,  32'h8000_0000, 1'b1, ism_pkg::ST_OK},
      '{ism_pkg::CMD_PUSH,  32'hFFFF_FFFF, 1'b1, ism_pkg::ST_OK},
      '{ism_pkg::CMD_MUL,   32'h0000_0000, 1'b0, ism_pkg::ST_OK},
      '{ism_pkg::CMD_PCHAR, 32'h0000_0000, 1'b1, ism_pkg::ST_RANGE},
      '{ism_pkg::CMD_PUSH,  32'h0000_0000, 1'b1, ism_pkg::ST_OK},
      '{ism_pkg::CMD_PCHAR, 32'h0000_0000, 1'b0, ism_pkg::ST_OK},
      '{ism_pkg::CMD_PUSH,  32'd72,        1'b1, ism_pkg::ST_OK},
      '{ism_pkg::CMD_PUSH,  32'd105,       1'b1, ism_pkg::ST_OK},
      '{ism_pkg::CMD_PSTR,  32'h0000_0000, 1'b0, ism_pkg::ST_OK},
      '{ism_pkg::CMD_ROTL,  32'h0000_0000, 1'b1, ism_pkg::ST_OK},
      '{ism_pkg::CMD_PSTR,  32'h0000_0000, 1'b0, ism_pkg::ST_OK},
      '{ism_pkg::CMD_PUSH,  32'd128,       1'b1, ism_pkg::ST_OK},
      '{ism_pkg::CMD_PSTR,  32'h0000_0000, 1'b0, ism_pkg::ST_OK},
      '{ism_pkg::CMD_PCHAR, 32'h0000_0000, 1'b1, ism_pkg::ST_RANGE},
      '{CMD_SPARE_LO,       32'hFFFF_FFFF, 1'b1, ism_pkg::ST_OK},
      '{CMD_SPARE_MID,      32'h0000_0000, 1'b1, ism_pkg::ST_OK},
      '{CMD_SPARE_HI,       32'h5555_AAAA, 1'b1, ism_pkg::ST_OK},
      '{ism_pkg::CMD_PUSH,  32'd127,       1'b1, ism_pkg::ST_OK},
      '{ism_pkg::CMD_PUSH,  32'd1,         1'b1, ism_pkg::ST_OK},
      '{ism_pkg::CMD_PSTR,  32'h0000_0000, 1'b0, ism_pkg::ST_OK}
   };

   integer_stack_machine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int slot_of(input int k);
      return (shadow_bottom + k) % ism_pkg::DEPTH;
   endfunction

   function automatic void add_beat(input ism_pkg::status_type st,
                                    input logic [ism_pkg::CHAR_W-1:0] ch,
                                    input logic vld, input logic lst);
      beat_type b;
      b.status     = st;
      b.character  = ch;
      b.char_valid = vld;
      b.last       = lst;
      command_beats.push_back(b);
   endfunction

   function automatic void clear_shadow();
      shadow_count  = 0;
      shadow_bottom = 0;
   endfunction

   // Applies one command to the shadow stack and leaves its beats in command_beats.
   function automatic void execute_command(input logic [ism_pkg::CMD_W-1:0] cmd,
                                           input logic [ism_pkg::DATA_W-1:0] val);
      logic [ism_pkg::DATA_W-1:0] top;
      logic [ism_pkg::DATA_W-1:0] v;
      int                         idx;
      int                         k;
      bit                         stop;
      command_beats.delete();
      case (cmd)
         ism_pkg::CMD_PUSH: begin
            if (shadow_count >= ism_pkg::DEPTH) begin
               clear_shadow();
               add_beat(ism_pkg::ST_FULL, '0, 1'b0, 1'b1);
            end else begin
               shadow_stack[slot_of(shadow_count)] = val;
               shadow_count++;
               add_beat(ism_pkg::ST_OK, '0, 1'b0, 1'b1);
            end
         end
         ism_pkg::CMD_MUL: begin
            if (shadow_count < 2) begin
               clear_shadow();
               add_beat(ism_pkg::ST_SHORT, '0, 1'b0, 1'b1);
            end else begin
               top = shadow_stack[slot_of(shadow_count - 1)];
               idx = slot_of(shadow_count - 2);
               shadow_stack[idx] = shadow_stack[idx] * top;
               shadow_count--;
               add_beat(ism_pkg::ST_OK, '0, 1'b0, 1'b1);
            end
         end
         ism_pkg::CMD_PCHAR: begin
            if (shadow_count == 0) begin
               clear_shadow();
               add_beat(ism_pkg::ST_EMPTY, '0, 1'b0, 1'b1);
            end else begin
               v = shadow_stack[slot_of(shadow_count - 1)];
               if (v > 32'd127) begin
                  clear_shadow();
                  add_beat(ism_pkg::ST_RANGE, '0, 1'b0, 1'b1);
               end else begin
                  add_beat(ism_pkg::ST_OK, v[ism_pkg::CHAR_W-1:0], 1'b1, 1'b0);
                  add_beat(ism_pkg::ST_OK, ism_pkg::NEWLINE_CHAR, 1'b1, 1'b1);
               end
            end
         end
         ism_pkg::CMD_PSTR: begin
            stop = 1'b0;
            for (k = shadow_count; k > 0 && !stop; k--) begin
               v = shadow_stack[slot_of(k - 1)];
               if (v == '0 || v >= 32'd128) begin
                  stop = 1'b1;
               end else begin
                  add_beat(ism_pkg::ST_OK, v[ism_pkg::CHAR_W-1:0], 1'b1, 1'b0);
               end
            end
            add_beat(ism_pkg::ST_OK, ism_pkg::NEWLINE_CHAR, 1'b1, 1'b1);
         end
         ism_pkg::CMD_ROTL: begin
            if (shadow_count >= 2) begin
               top = shadow_stack[slot_of(shadow_count - 1)];
               shadow_bottom = (shadow_bottom + ism_pkg::DEPTH - 1) % ism_pkg::DEPTH;
               shadow_stack[shadow_bottom] = top;
            end
            add_beat(ism_pkg::ST_OK, '0, 1'b0, 1'b1);
         end
         default: begin
            add_beat(ism_pkg::ST_OK, '0, 1'b0, 1'b1);
         end
      endcase
   endfunction

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [ism_pkg::DATA_W-1:0] random_push_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom_range(1, 127);
      if (r < 65) return '0;
      if (r < 75) return $urandom_range(128, 255);
      return $urandom();
   endfunction

   function automatic logic [ism_pkg::CMD_W-1:0] random_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return ism_pkg::CMD_PUSH;
      if (r < 50) return ism_pkg::CMD_MUL;
      if (r < 65) return ism_pkg::CMD_PCHAR;
      if (r < 80) return ism_pkg::CMD_PSTR;
      if (r < 95) return ism_pkg::CMD_ROTL;
      return ism_pkg::CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
   endfunction

   // Called and returns at a falling edge; req_tvalid stays high on return.
   task automatic send_item(input logic [ism_pkg::CMD_W-1:0] cmd,
                            input logic [ism_pkg::DATA_W-1:0] val,
                            input logic typed, input ism_pkg::status_type exp_status);
      int       gap;
      beat_type b;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = val;
      do @(posedge clock); while (!req_tready);
      execute_command(cmd, val);
      if (typed) begin
         b.status     = exp_status;
         b.character  = '0;
         b.char_valid = 1'b0;
         b.last       = 1'b1;
         expected_beats.push_back(b);
      end else begin
         foreach (command_beats[j]) expected_beats.push_back(command_beats[j]);
      end
      commands_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(input logic [ism_pkg::CMD_W-1:0] cmd);
      send_item(cmd, (cmd == ism_pkg::CMD_PUSH) ? random_push_value() :
                logic'($urandom()) ? 32'hFFFF_FFFF : 32'h0, 1'b0, ism_pkg::ST_OK);
   endtask

   always @(negedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready = 1'b0;
      end else if (no_idle || r < 65) begin
         rsp_tready = 1'b1;
      end else if (r < 93) begin
         stall_left = $urandom_range(0, 2);
         rsp_tready = 1'b0;
      end else begin
         stall_left = $urandom_range(10, 40);
         rsp_tready = 1'b0;
      end
   end

   always @(posedge clock) begin
      beat_type                   want;
      logic [ism_pkg::CHAR_W-1:0] got_char;
      logic                       got_valid;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_char  = rsp_tdata[9:3];
         got_valid = rsp_tdata[10];
         if (expected_beats.size() == 0) begin
            error_count++;
            $display("%0t: expected no beat, got status %0d char %0d valid %0b last %0b",
                     $time, rsp_tdata[2:0], got_char, got_valid, rsp_tlast);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_tdata[2:0] !== want.status || got_char !== want.character ||
                got_valid !== want.char_valid || rsp_tlast !== want.last ||
                rsp_tdata[ism_pkg::RSP_DATA_W-1:11] !== '0) begin
               error_count++;
               $display("%0t: expected status %0d char %0d valid %0b last %0b pad 0",
                        $time, want.status, want.character, want.char_valid, want.last);
               $display("%0t: got      status %0d char %0d valid %0b last %0b pad %0h",
                        $time, rsp_tdata[2:0], got_char, got_valid, rsp_tlast,
                        rsp_tdata[ism_pkg::RSP_DATA_W-1:11]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_integer_stack_machine NOT OK");
            $finish;
         end
      end
   end

   initial begin
      int r;
      int n;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      rsp_tready    = 1'b0;
      no_idle       = 1'b0;
      error_count   = 0;
      idle_cycles   = 0;
      commands_sent = 0;
      stall_left    = 0;
      clear_shadow();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < NUM_ROWS; i++)
         send_item(directed_rows[i].cmd, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].status);

      // fill to the brim, print the lot, wrap, then overflow
      for (int i = 0; i < ism_pkg::DEPTH - 2; i++)
         send_item(ism_pkg::CMD_PUSH, $urandom_range(1, 127), 1'b0, ism_pkg::ST_OK);
      send_item(ism_pkg::CMD_PSTR, '0, 1'b0, ism_pkg::ST_OK);
      send_item(ism_pkg::CMD_ROTL, '0, 1'b0, ism_pkg::ST_OK);
      send_item(ism_pkg::CMD_PUSH, 32'h1234_5678, 1'b1, ism_pkg::ST_FULL);
      send_item(ism_pkg::CMD_PCHAR, '0, 1'b1, ism_pkg::ST_EMPTY);
      wait_drained();

      while (commands_sent < TOTAL_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 6) begin
            n = $urandom_range(ism_pkg::DEPTH - 4, ism_pkg::DEPTH + 2);
            for (int i = 0; i < n; i++)
               send_item(ism_pkg::CMD_PUSH, random_push_value(), 1'b0, ism_pkg::ST_OK);
            send_item(ism_pkg::CMD_PSTR, '0, 1'b0, ism_pkg::ST_OK);
         end else if (r < 8) begin
            wait_drained();
         end else if (r < 11) begin
            no_idle = !no_idle;
         end else begin
            send_random(random_command());
         end
      end
      req_tvalid = 1'b0;

      while (expected_beats.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_integer_stack_machine OK");
      end else begin
         $display("tb_integer_stack_machine NOT OK");
      end
      $finish;
   end

endmodule
